@@ rtl/edfs_pkg.sv @@
`default_nettype none

package edfs_pkg;

  localparam int unsigned TASK_SLOTS = 16;
  localparam int unsigned SLOT_W     = $clog2(TASK_SLOTS);
  localparam int unsigned ID_W       = 16;
  localparam int unsigned DL_W       = 32;
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned STATUS_W   = 2;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RAN     = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [ID_W-1:0]    task_id;
    logic [DL_W-1:0]    task_deadline;
    logic [BURST_W-1:0] task_burst;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     run_id;
    logic                dispatched;
    logic                finished;
    logic                preempted;
    logic [ID_W-1:0]     preempted_id;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DL_W-1:0]    deadline;
    logic [BURST_W-1:0] remaining;
  } slot_t;

  localparam int unsigned SLOT_BITS = $bits(slot_t);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FINAL = 4'b1000
  } state_e;

endpackage

`default_nettype wire

@@ rtl/edfs_if.sv @@
`default_nettype none

interface edfs_in_if import edfs_pkg::*;;
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface edfs_out_if import edfs_pkg::*;;
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/edfs_ram.sv @@
`default_nettype none

module edfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/edf_preemptive_scheduler.sv @@
// Arrival word: result registered in the cycle after acceptance.
// Tick word: the accept cycle, one slot-memory read per cycle over all TASK_SLOTS slots,
// then a drain state and a write-back state (S_FINAL), which waits for the result register
// to free and registers the result as it writes the chosen slot back.
// One word is in work at a time; the next is taken once the result register frees.
// Reset clears slot occupancy, the running task and the output valid flag;
// slot memory contents are not cleared.
`default_nettype none

module edf_preemptive_scheduler import edfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  edfs_in_if.sink      in_i,
  edfs_out_if.source   out_o
);

  state_e                state_q, state_d;
  logic [TASK_SLOTS-1:0] used_q, used_d;
  logic                  run_vld_q, run_vld_d;
  logic [SLOT_W-1:0]     run_slot_q, run_slot_d;
  logic [SLOT_W-1:0]     scan_q, scan_d;
  logic                  rd_vld_q;
  logic [SLOT_W-1:0]     rd_idx_q;
  logic                  best_vld_q, best_vld_d;
  logic [SLOT_W-1:0]     best_idx_q, best_idx_d;
  slot_t                 best_q, best_d;
  slot_t                 run_ent_q, run_ent_d;
  logic                  out_vld_q, out_vld_d;
  out_word_t             out_q, out_d;

  logic                  ram_en, ram_we;
  logic [SLOT_W-1:0]     ram_addr;
  slot_t                 ram_wdata, ram_rdata;
  logic [SLOT_BITS-1:0]  ram_rdata_raw;

  logic                  out_free, accept;
  logic                  free_vld;
  logic [SLOT_W-1:0]     free_idx;
  logic                  preempt, use_cand, ch_vld, ch_finish;
  logic [SLOT_W-1:0]     ch_idx;
  slot_t                 ch_ent;
  logic [BURST_W-1:0]    ch_rem_new;

  edfs_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (TASK_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = slot_t'(ram_rdata_raw);

  assign out_free      = !out_vld_q || out_o.ready;
  assign in_i.ready    = (state_q == S_IDLE) && out_free;
  assign accept        = in_i.valid && in_i.ready;
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_vld = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign preempt    = run_vld_q && best_vld_q && (best_q.deadline < run_ent_q.deadline);
  assign use_cand   = preempt || !run_vld_q;
  assign ch_vld     = use_cand ? best_vld_q : run_vld_q;
  assign ch_idx     = use_cand ? best_idx_q : run_slot_q;
  assign ch_ent     = use_cand ? best_q : run_ent_q;
  assign ch_finish  = (ch_ent.remaining <= BURST_W'(1));
  assign ch_rem_new = (ch_ent.remaining == '0) ? '0 : ch_ent.remaining - BURST_W'(1);

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    run_vld_d  = run_vld_q;
    run_slot_d = run_slot_q;
    scan_d     = scan_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    run_ent_d  = run_ent_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_d      = out_q;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = scan_q;
    ram_wdata  = ch_ent;

    // fold the slot read last cycle into the running capture or the best candidate
    if (rd_vld_q && used_q[rd_idx_q]) begin
      if (run_vld_q && (rd_idx_q == run_slot_q)) begin
        run_ent_d = ram_rdata;
      end else if (!best_vld_q || (ram_rdata.deadline < best_q.deadline)) begin
        best_vld_d = 1'b1;
        best_idx_d = rd_idx_q;
        best_d     = ram_rdata;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.payload.operation == OP_ARRIVE) begin
            out_vld_d = 1'b1;
            out_d     = '0;
            if (free_vld) begin
              ram_en            = 1'b1;
              ram_we            = 1'b1;
              ram_addr          = free_idx;
              ram_wdata.id        = in_i.payload.task_id;
              ram_wdata.deadline  = in_i.payload.task_deadline;
              ram_wdata.remaining = in_i.payload.task_burst;
              used_d[free_idx]  = 1'b1;
              out_d.status      = ST_STORED;
            end else begin
              out_d.status = ST_DROPPED;
            end
          end else begin
            best_vld_d = 1'b0;
            scan_d     = '0;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_en = 1'b1;
        scan_d = scan_q + SLOT_W'(1);
        if (scan_q == SLOT_W'(TASK_SLOTS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '0;
          state_d   = S_IDLE;
          if (ch_vld) begin
            ram_en              = 1'b1;
            ram_we              = 1'b1;
            ram_addr            = ch_idx;
            ram_wdata.remaining = ch_rem_new;
            run_vld_d           = !ch_finish;
            run_slot_d          = ch_idx;
            if (ch_finish) begin
              used_d[ch_idx] = 1'b0;
            end
            out_d.status       = ST_RAN;
            out_d.run_id       = ch_ent.id;
            out_d.dispatched   = use_cand;
            out_d.finished     = ch_finish;
            out_d.preempted    = preempt;
            out_d.preempted_id = preempt ? run_ent_q.id : '0;
          end else begin
            run_vld_d    = 1'b0;
            out_d.status = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      run_vld_q  <= 1'b0;
      run_slot_q <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      run_vld_q  <= run_vld_d;
      run_slot_q <= run_slot_d;
      rd_vld_q   <= (state_q == S_SCAN);
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    rd_idx_q   <= scan_q;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    run_ent_q  <= run_ent_d;
    out_q      <= out_d;
  end

  a_run_slot_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q |-> used_q[run_slot_q])
    else $error("running slot is not occupied");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) || (state_q == S_DRAIN)) |-> !ram_we)
    else $error("slot memory written during scan");

  a_best_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINAL) && best_vld_q && run_vld_q) |-> (best_idx_q != run_slot_q))
    else $error("candidate equals running slot");

  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.payload.operation == OP_TICK)) |=> (state_q == S_SCAN))
    else $error("tick did not start a scan");

  a_finish_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINAL) && out_free && ch_vld && ch_finish) |=> !run_vld_q)
    else $error("finished task still running");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top;
  import edfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = TASK_SLOTS + 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  edfs_in_if  in_if ();
  edfs_out_if out_if ();

  edf_preemptive_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10ns clk_i = ~clk_i;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_left = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  slot_t       task_slot [TASK_SLOTS];
  logic        slot_busy [TASK_SLOTS];
  logic        run_valid = 1'b0;
  int          run_slot = 0;
  out_word_t   expected_outcomes [$];

  initial begin
    for (int s = 0; s < TASK_SLOTS; s++) begin
      slot_busy[s] = 1'b0;
      task_slot[s] = '0;
    end
  end

  function automatic int earliest_waiting_slot();
    int best = TASK_SLOTS;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      if (!slot_busy[s] || (run_valid && s == run_slot)) continue;
      if (best == TASK_SLOTS || task_slot[s].deadline < task_slot[best].deadline) best = s;
    end
    return best;
  endfunction

  function automatic out_word_t predict_schedule(in_word_t w);
    out_word_t r;
    int pick;
    int free_s;
    r = '0;
    if (w.operation == OP_ARRIVE) begin
      free_s = TASK_SLOTS;
      for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
        if (!slot_busy[s]) free_s = s;
      end
      if (free_s != TASK_SLOTS) begin
        slot_busy[free_s] = 1'b1;
        task_slot[free_s].id = w.task_id;
        task_slot[free_s].deadline = w.task_deadline;
        task_slot[free_s].remaining = w.task_burst;
        r.status = ST_STORED;
      end else begin
        r.status = ST_DROPPED;
      end
    end else begin
      pick = earliest_waiting_slot();
      if (run_valid && pick != TASK_SLOTS &&
          task_slot[pick].deadline < task_slot[run_slot].deadline) begin
        r.preempted = 1'b1;
        r.preempted_id = task_slot[run_slot].id;
        run_valid = 1'b0;
      end
      if (!run_valid) begin
        pick = earliest_waiting_slot();
        if (pick != TASK_SLOTS) begin
          run_valid = 1'b1;
          run_slot = pick;
          r.dispatched = 1'b1;
        end
      end
      if (run_valid) begin
        r.run_id = task_slot[run_slot].id;
        if (task_slot[run_slot].remaining != '0)
          task_slot[run_slot].remaining = task_slot[run_slot].remaining - BURST_W'(1);
        if (task_slot[run_slot].remaining == '0) begin
          slot_busy[run_slot] = 1'b0;
          run_valid = 1'b0;
          r.finished = 1'b1;
        end
        r.status = ST_RAN;
      end else begin
        r.status = ST_IDLE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // predict on every accepted input word
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      expected_outcomes.push_back(predict_schedule(in_if.payload));
  end

  always @(posedge clk_i) begin : check_results
    out_word_t want;
    out_word_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result word", 32'(got.status), 32'd0);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.run_id !== want.run_id)
          report_mismatch("run_id", 32'(got.run_id), 32'(want.run_id));
        if (got.dispatched !== want.dispatched)
          report_mismatch("dispatched", 32'(got.dispatched), 32'(want.dispatched));
        if (got.finished !== want.finished)
          report_mismatch("finished", 32'(got.finished), 32'(want.finished));
        if (got.preempted !== want.preempted)
          report_mismatch("preempted", 32'(got.preempted), 32'(want.preempted));
        if (got.preempted_id !== want.preempted_id)
          report_mismatch("preempted_id", 32'(got.preempted_id), 32'(want.preempted_id));
      end
    end
  end

  // hold off the result side during a stall, else idle at random
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic op, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                           logic [BURST_W-1:0] burst);
    in_word_t w;
    w.operation = op;
    w.task_id = id;
    w.task_deadline = dl;
    w.task_burst = burst;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_arrival(logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                              logic [BURST_W-1:0] burst);
    send_word(OP_ARRIVE, id, dl, burst);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, ID_W'($urandom), $urandom, BURST_W'($urandom));
  endtask

  task automatic send_random_arrival();
    logic [DL_W-1:0] dl;
    logic [BURST_W-1:0] burst;
    int pick;
    dl = ($urandom_range(0, 99) < 75) ? DL_W'($urandom_range(0, 63)) : $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 97)
      burst = BURST_W'($urandom_range(1, 4));
    else if (pick < 99)
      burst = BURST_W'($urandom_range(5, 64));
    else
      burst = BURST_W'($urandom_range(1, 65535));
    send_arrival(ID_W'($urandom), dl, burst);
  endtask

  task automatic test_idle_tick();
    send_tick();
  endtask

  task automatic test_single_task();
    send_arrival(16'hFFFF, 32'hFFFF_FFFF, 16'd2);
    send_tick();
    send_tick();
    // leave a long background task at the latest deadline
    send_arrival(16'hA5A5, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_zero_burst();
    send_arrival(16'h0000, 32'h0000_0000, 16'd0);
    send_tick();
  endtask

  task automatic test_preempt_and_ties();
    send_arrival(16'h0011, 32'd100, 16'd3);
    send_tick();
    send_arrival(16'h0022, 32'd100, 16'd1);
    send_tick();
    send_arrival(16'h0033, 32'd50, 16'd2);
    send_arrival(16'h0044, 32'd50, 16'd1);
    repeat (6) send_tick();
  endtask

  task automatic test_full_stall();
    stall_left = HOLD_CYCLES;
    repeat (20) send_random_arrival();
    repeat (12) send_tick();
  endtask

  task automatic test_random_mix(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 70)
        send_tick();
      else
        send_random_arrival();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 66;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_tick();
    test_single_task();
    test_zero_burst();
    test_preempt_and_ties();
    test_full_stall();
    test_random_mix(250);

    send_idle_pct = 66;
    recv_idle_pct = 19;
    test_random_mix(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(250);

    in_if.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
